### hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;

    // queue entry between the byte front end and the compression engine
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } item_t;

    localparam int unsigned ItemW = 10;
    localparam logic [7:0]  PadByte = 8'h80;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t initial_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic word_t ror32(input word_t v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic word_t big_sig0(input word_t a);
        return ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
    endfunction

    function automatic word_t big_sig1(input word_t e);
        return ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
    endfunction

    function automatic word_t small_sig0(input word_t w);
        return ror32(w, 7) ^ ror32(w, 18) ^ (w >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t w);
        return ror32(w, 17) ^ ror32(w, 19) ^ (w >> 10);
    endfunction

endpackage

### hw/rtl/sha_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if
// message byte channel: valid, ready and one byte item
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

### hw/rtl/sha_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_out_if
// digest channel: valid, ready and one 64-bit digest part
// ----------------------------------------------------------------------------
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    modport source (output valid, digest_part, part_index, last_part, input ready);
    modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface

### hw/rtl/sha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### hw/rtl/sha_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_queue
// small fifo of byte items between the input port and the engine
// ----------------------------------------------------------------------------
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned Depth = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);
    localparam int unsigned AW = $clog2(Depth);

    item_t           slot_reg [Depth];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full     = (count_reg == (AW+1)'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

### hw/rtl/sha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_engine
// byte absorb, padding, message schedule and one-round-per-cycle compression
// ----------------------------------------------------------------------------
module sha_engine
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_avail,
    input  item_t       item,
    output logic        item_pop,
    output logic        dig_valid,
    input  logic        dig_ready,
    output logic [63:0] dig_part,
    output logic [1:0]  dig_index,
    output logic        dig_last
);
    typedef enum logic [6:0] {
        S_ABSORB = 7'b0000001,
        S_PAD    = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_ROUND  = 7'b0001000,
        S_FOLD   = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_WAIT   = 7'b1000000
    } state_t;

    state_t       state_reg, state_next;
    logic [60:0]  count_reg;
    logic [5:0]   pad_ptr_reg;
    logic         finish_reg;   // padding in progress for a last item
    logic         len_blk_reg;  // current pad block carries the length
    logic [6:0]   step_reg;     // load index 0..64, then round index
    word_t        h_reg [8];
    word_t        r_reg [8];
    word_t        w_reg [16];
    logic [1:0]   part_reg;

    // buffer ram
    logic        ram_we;
    logic [5:0]  ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    sha_ram #(.Width(8), .Depth(64)) u_buf (
        .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    logic [63:0] bit_len;
    logic [5:0]  fill;
    assign bit_len = {count_reg, 3'b000};
    assign fill    = count_reg[5:0];

    // pad byte at pad_ptr
    logic [7:0] pad_byte;
    always_comb
    begin
        if (len_blk_reg && pad_ptr_reg >= 6'd56)
        begin
            pad_byte = bit_len[8*(6'd63 - pad_ptr_reg) +: 8];
        end
        else if (pad_ptr_reg == fill && !len_blk_reg)
        begin
            pad_byte = PadByte;
        end
        else if (pad_ptr_reg == fill && len_blk_reg && fill < 6'd56)
        begin
            pad_byte = PadByte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // schedule word t >= 16 from the 16-word window
    word_t w_new;
    assign w_new = w_reg[0] + small_sig0(w_reg[1]) + w_reg[9] + small_sig1(w_reg[14]);

    word_t t1, t2;
    assign t1 = r_reg[7] + big_sig1(r_reg[4]) + ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]))
              + round_k(step_reg[5:0]) + w_reg[0];
    assign t2 = big_sig0(r_reg[0])
              + ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]));

    logic absorb_fire;
    assign absorb_fire = (state_reg == S_ABSORB) && item_avail;
    assign item_pop    = absorb_fire;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill;
        ram_wdata = item.data_byte;
        ram_raddr = step_reg[5:0];
        state_next = state_reg;
        case (state_reg)
            S_ABSORB:
            begin
                if (absorb_fire && item.byte_valid)
                begin
                    ram_we = 1'b1;
                end
                if (absorb_fire)
                begin
                    if (item.byte_valid && fill == 6'd63)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (item.last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pad_ptr_reg;
                ram_wdata  = pad_byte;
                if (pad_ptr_reg == 6'd63)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (step_reg == 7'd64)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (step_reg == 7'd63)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (!finish_reg)
                begin
                    state_next = S_WAIT;
                end
                else if (len_blk_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_WAIT:
            begin
                state_next = finish_reg ? S_PAD : S_ABSORB;
            end
            S_EMIT:
            begin
                if (dig_ready && part_reg == 2'd3)
                begin
                    state_next = S_ABSORB;
                end
            end
            default: state_next = S_ABSORB;
        endcase
    end

    assign dig_valid = (state_reg == S_EMIT);
    assign dig_index = part_reg;
    assign dig_last  = (part_reg == 2'd3);
    assign dig_part  = {h_reg[{part_reg, 1'b0}], h_reg[{part_reg, 1'b1}]};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && step_reg != 7'd0)
        begin
            // shift bytes in; a full word every four
            for (int i = 0; i < 15; i++)
            begin
                if (step_reg[1:0] == 2'd1)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
            end
            w_reg[15] <= (step_reg[1:0] == 2'd1) ? {24'h0, ram_rdata}
                                                 : {w_reg[15][23:0], ram_rdata};
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        if (state_reg == S_LOAD)
        begin
            for (int j = 0; j < 8; j++)
            begin
                r_reg[j] <= h_reg[j];
            end
        end
        else if (state_reg == S_ROUND)
        begin
            r_reg[7] <= r_reg[6]; r_reg[6] <= r_reg[5]; r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2]; r_reg[2] <= r_reg[1]; r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ABSORB;
            count_reg   <= '0;
            pad_ptr_reg <= '0;
            finish_reg  <= 1'b0;
            len_blk_reg <= 1'b0;
            step_reg    <= '0;
            part_reg    <= '0;
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= initial_hash(3'(j));
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_ABSORB:
                begin
                    step_reg <= '0;
                    if (absorb_fire)
                    begin
                        if (item.byte_valid)
                        begin
                            count_reg <= count_reg + 61'd1;
                        end
                        if (item.last)
                        begin
                            finish_reg <= 1'b1;
                            if (item.byte_valid && fill == 6'd63)
                            begin
                                // last byte fills the block: a whole pad block follows
                                pad_ptr_reg <= '0;
                                len_blk_reg <= 1'b0;
                            end
                            else
                            begin
                                pad_ptr_reg <= item.byte_valid ? fill + 6'd1 : fill;
                                len_blk_reg <= item.byte_valid ? (fill + 6'd1 < 6'd56)
                                                               : (fill < 6'd56);
                            end
                        end
                    end
                end
                S_PAD:
                begin
                    pad_ptr_reg <= pad_ptr_reg + 6'd1;
                    step_reg    <= '0;
                end
                S_LOAD:
                begin
                    step_reg <= (step_reg == 7'd64) ? 7'd0 : step_reg + 7'd1;
                end
                S_ROUND:
                begin
                    step_reg <= step_reg + 7'd1;
                end
                S_FOLD:
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        h_reg[j] <= h_reg[j] + r_reg[j];
                    end
                    if (finish_reg && !len_blk_reg)
                    begin
                        // next pad block carries the length; it also holds the pad byte when no earlier pad block did
                        len_blk_reg <= 1'b1;
                        pad_ptr_reg <= '0;
                    end
                    part_reg <= '0;
                end
                S_WAIT:
                begin
                    step_reg <= '0;
                end
                S_EMIT:
                begin
                    if (dig_ready)
                    begin
                        part_reg <= part_reg + 2'd1;
                        if (part_reg == 2'd3)
                        begin
                            count_reg  <= '0;
                            finish_reg <= 1'b0;
                            for (int j = 0; j < 8; j++)
                            begin
                                h_reg[j] <= initial_hash(3'(j));
                            end
                        end
                    end
                end
                default: step_reg <= '0;
            endcase
        end
    end
endmodule

### hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// sha-256 of a byte stream, digest as four 64-bit big-endian parts
// ----------------------------------------------------------------------------
//  channel   direction  payload                               transfer
//  in_ch     sink       data_byte, byte_valid, last           valid & ready
//  out_ch    source     digest_part, part_index, last_part    valid & ready
//
//  one byte per cycle is absorbed into the block ram while the engine waits and the queue is not empty
//  each full data block then passes through load, rounds, fold and wait
//  the last item adds a pad pass for each pad block (one or two),
//  each followed by load, rounds and fold, then 4 digest parts
//  reset restores the initial hash value and clears the byte count
//  a four-entry queue lets the input keep taking bytes while the engine works
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int unsigned QueueDepth = 4
) (
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    item_t q_in, q_out;
    logic  q_full, q_empty, q_pop;

    assign q_in.data_byte  = in_ch.data_byte;
    assign q_in.byte_valid = in_ch.byte_valid;
    assign q_in.last       = in_ch.last;
    assign in_ch.ready     = !q_full;

    // front: queue of accepted items
    sha_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_ch.valid && !q_full), .push_item(q_in), .full(q_full),
        .pop(q_pop), .pop_item(q_out), .empty(q_empty)
    );

    // back: absorb, pad, compress, emit digest
    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .item_avail(!q_empty), .item(q_out), .item_pop(q_pop),
        .dig_valid(out_ch.valid), .dig_ready(out_ch.ready),
        .dig_part(out_ch.digest_part), .dig_index(out_ch.part_index),
        .dig_last(out_ch.last_part)
    );

    // last part always carries index three
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_part |-> out_ch.part_index == 2'd3)
        else $error("last_part without index three");

    // engine never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // a taken non-final part advances the index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_part
        |=> out_ch.valid && out_ch.part_index == $past(out_ch.part_index) + 2'd1)
        else $error("digest part sequence broken");
endmodule
